// ----- rtl/lel_pkg.sv -----
// ----------------------------------------------------------------------------
// lel_pkg
// Shared codes and reset values for the link event limiter and supervisor.
// ----------------------------------------------------------------------------
package lel_pkg;

  localparam int TimeW   = 32;
  localparam int CountW  = 32;
  localparam int BudgetW = 8;
  localparam int ReasonW = 8;
  localparam int OpW     = 2;
  localparam int KindW   = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 32;

  localparam logic [OpW-1:0] OP_LINK_EVENT = 2'd0;
  localparam logic [OpW-1:0] OP_TICK       = 2'd1;
  localparam logic [OpW-1:0] OP_ARM        = 2'd2;

  localparam logic [KindW-1:0] KIND_OTHER  = 2'd0;
  localparam logic [KindW-1:0] KIND_DISC   = 2'd1;
  localparam logic [KindW-1:0] KIND_GOT_IP = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_LINE_BUDGET = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WINDOW      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KICK_PACE   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RECENT_DISC = 3'd4;

  localparam logic [BudgetW-1:0] LINE_BUDGET_RST = 8'd10;
  localparam logic [TimeW-1:0]   WINDOW_RST      = 32'd60000;
  localparam logic [TimeW-1:0]   THRESHOLD_RST   = 32'd60000;
  localparam logic [TimeW-1:0]   KICK_PACE_RST   = 32'd30000;
  localparam logic [TimeW-1:0]   RECENT_DISC_RST = 32'd5000;

endpackage

// ----- rtl/link_event_limiter_and_supervisor_core.sv -----
// ----------------------------------------------------------------------------
// link_event_limiter_and_supervisor_core
// Rate limits link event log lines and raises paced reconnect kicks.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless the output stalls: an
// input register holds the item, and one pass of wrapping subtractions and
// compares against the state registers fills the result register. Results
// come out in order, one per item. Configuration writes are meant for idle
// periods only.
// ----------------------------------------------------------------------------
module link_event_limiter_and_supervisor_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lel_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [lel_pkg::CfgW-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lel_pkg::OpW-1:0]       operation,
  input  logic [lel_pkg::KindW-1:0]     event_kind,
  input  logic [lel_pkg::ReasonW-1:0]   disc_reason,
  input  logic [lel_pkg::TimeW-1:0]     now_ms,
  input  logic                          link_up,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          log_event,
  output logic                          log_summary,
  output logic [lel_pkg::CountW-1:0]    suppressed_total,
  output logic                          kick,
  output logic [lel_pkg::CountW-1:0]    kick_total,
  output logic [lel_pkg::TimeW-1:0]     outage_ms,
  output logic [lel_pkg::CountW-1:0]    disc_total,
  output logic [lel_pkg::ReasonW-1:0]   last_reason
);
  import lel_pkg::*;

  logic [BudgetW-1:0] line_budget;
  logic [TimeW-1:0]   window_ms;
  logic [TimeW-1:0]   outage_threshold_ms;
  logic [TimeW-1:0]   kick_pace_ms;
  logic [TimeW-1:0]   recent_disc_ms;

  logic               s1_valid;
  logic [OpW-1:0]     s1_op;
  logic [KindW-1:0]   s1_kind;
  logic [ReasonW-1:0] s1_reason;
  logic [TimeW-1:0]   s1_now;
  logic               s1_up;

  logic [CountW-1:0]  disc_count;
  logic [ReasonW-1:0] last_reason_reg;
  logic [TimeW-1:0]   last_disc_time;
  logic [TimeW-1:0]   last_got_ip_time;
  logic [TimeW-1:0]   window_start;
  logic [BudgetW-1:0] window_lines;
  logic [CountW-1:0]  suppressed_count;
  logic [TimeW-1:0]   outage_start;
  logic [TimeW-1:0]   last_kick_time;
  logic               armed;
  logic [CountW-1:0]  kick_count;

  logic [CountW-1:0]  disc_count_next;
  logic [ReasonW-1:0] last_reason_reg_next;
  logic [TimeW-1:0]   last_disc_time_next;
  logic [TimeW-1:0]   last_got_ip_time_next;
  logic [TimeW-1:0]   window_start_next;
  logic [BudgetW-1:0] window_lines_next;
  logic [CountW-1:0]  suppressed_count_next;
  logic [TimeW-1:0]   outage_start_next;
  logic [TimeW-1:0]   last_kick_time_next;
  logic               armed_next;
  logic [CountW-1:0]  kick_count_next;

  logic               log_event_next;
  logic               log_summary_next;
  logic [CountW-1:0]  suppressed_total_next;
  logic               kick_next;
  logic [TimeW-1:0]   outage_ms_next;

  logic               out_free;
  logic               s1_fire;
  logic               in_accept;

  logic               roll;
  logic [BudgetW-1:0] lines_eff;
  logic [CountW-1:0]  supp_eff;
  logic               sup_active;
  logic [TimeW-1:0]   disc_age;
  logic               anchor_disc;
  logic [TimeW-1:0]   outage_age;
  logic [TimeW-1:0]   kick_age;
  logic               kick_ok;

  assign out_free  = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    disc_count_next       = disc_count;
    last_reason_reg_next  = last_reason_reg;
    last_disc_time_next   = last_disc_time;
    last_got_ip_time_next = last_got_ip_time;
    window_start_next     = window_start;
    window_lines_next     = window_lines;
    suppressed_count_next = suppressed_count;
    outage_start_next     = outage_start;
    last_kick_time_next   = last_kick_time;
    armed_next            = armed;
    kick_count_next       = kick_count;
    log_event_next        = 1'b0;
    log_summary_next      = 1'b0;
    suppressed_total_next = '0;
    kick_next             = 1'b0;
    outage_ms_next        = '0;

    roll      = (s1_now - window_start) >= window_ms;
    lines_eff = roll ? '0 : window_lines;
    supp_eff  = roll ? '0 : suppressed_count;

    sup_active  = (last_got_ip_time != '0) || armed;
    disc_age    = s1_now - last_disc_time;
    anchor_disc = (last_disc_time != '0) && (disc_age < recent_disc_ms);
    kick_age    = s1_now - last_kick_time;
    if (outage_start != '0) begin
      outage_age = s1_now - outage_start;
    end else if (anchor_disc) begin
      outage_age = disc_age;
    end else begin
      outage_age = '0;
    end
    kick_ok = (outage_age >= outage_threshold_ms) &&
              ((last_kick_time == '0) || (kick_age >= kick_pace_ms));

    case (s1_op)
      OP_LINK_EVENT: begin
        if (s1_kind == KIND_DISC) begin
          disc_count_next      = disc_count + 1'b1;
          last_reason_reg_next = s1_reason;
          last_disc_time_next  = s1_now;
        end else if (s1_kind == KIND_GOT_IP) begin
          last_got_ip_time_next = s1_now;
        end
        if (roll) begin
          window_start_next = s1_now;
          if (suppressed_count != '0) begin
            log_summary_next      = 1'b1;
            suppressed_total_next = suppressed_count;
          end
        end
        if (lines_eff >= line_budget) begin
          window_lines_next     = lines_eff;
          suppressed_count_next = supp_eff + 1'b1;
        end else begin
          window_lines_next     = lines_eff + 1'b1;
          suppressed_count_next = supp_eff;
          log_event_next        = 1'b1;
        end
      end
      OP_TICK: begin
        if (sup_active) begin
          if (s1_up) begin
            outage_start_next   = '0;
            last_kick_time_next = '0;
          end else begin
            if (outage_start == '0) begin
              outage_start_next = anchor_disc ? last_disc_time : s1_now;
            end
            if (kick_ok) begin
              last_kick_time_next = s1_now;
              kick_count_next     = kick_count + 1'b1;
              kick_next           = 1'b1;
              outage_ms_next      = outage_age;
            end
          end
        end
      end
      OP_ARM: begin
        armed_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_budget         <= LINE_BUDGET_RST;
      window_ms           <= WINDOW_RST;
      outage_threshold_ms <= THRESHOLD_RST;
      kick_pace_ms        <= KICK_PACE_RST;
      recent_disc_ms      <= RECENT_DISC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_BUDGET: line_budget         <= cfg_data[BudgetW-1:0];
        REG_WINDOW:      window_ms           <= cfg_data[TimeW-1:0];
        REG_THRESHOLD:   outage_threshold_ms <= cfg_data[TimeW-1:0];
        REG_KICK_PACE:   kick_pace_ms        <= cfg_data[TimeW-1:0];
        REG_RECENT_DISC: recent_disc_ms      <= cfg_data[TimeW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
    if (in_accept) begin
      s1_op     <= operation;
      s1_kind   <= event_kind;
      s1_reason <= disc_reason;
      s1_now    <= now_ms;
      s1_up     <= link_up;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disc_count       <= '0;
      last_reason_reg  <= '0;
      last_disc_time   <= '0;
      last_got_ip_time <= '0;
      window_start     <= '0;
      window_lines     <= '0;
      suppressed_count <= '0;
      outage_start     <= '0;
      last_kick_time   <= '0;
      armed            <= 1'b0;
      kick_count       <= '0;
    end else if (s1_fire) begin
      disc_count       <= disc_count_next;
      last_reason_reg  <= last_reason_reg_next;
      last_disc_time   <= last_disc_time_next;
      last_got_ip_time <= last_got_ip_time_next;
      window_start     <= window_start_next;
      window_lines     <= window_lines_next;
      suppressed_count <= suppressed_count_next;
      outage_start     <= outage_start_next;
      last_kick_time   <= last_kick_time_next;
      armed            <= armed_next;
      kick_count       <= kick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
    if (s1_fire) begin
      log_event        <= log_event_next;
      log_summary      <= log_summary_next;
      suppressed_total <= suppressed_total_next;
      kick             <= kick_next;
      kick_total       <= kick_count_next;
      outage_ms        <= outage_ms_next;
      disc_total       <= disc_count_next;
      last_reason      <= last_reason_reg_next;
    end
  end

  // A summary line always reports a nonzero suppressed count.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && log_summary |-> suppressed_total != '0)
    else $error("summary without suppressed events");

  // Limiter results and supervisor kicks come from different operations.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kick |-> !log_event && !log_summary)
    else $error("kick reported with a log line");

  // A kick always advances the kick counter.
  assert property (@(posedge clk) disable iff (rst)
    s1_fire && kick_next |=> kick_count == $past(kick_count) + 1'b1)
    else $error("kick counter did not advance");

  // The input side only stalls while the input register is occupied.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("stall with empty input register");

endmodule
